// File: design/fmf_pkg.sv
package fmf_pkg;

  localparam int unsigned NUM_FAULTS = 8;

  localparam int unsigned FAULT_ID_W = 4;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned SUM_W      = $clog2(NUM_FAULTS + 1);

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAT_THR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEAL_THR = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0] MAT_THR_RST  = THR_W'(5);
  localparam logic [THR_W-1:0] HEAL_THR_RST = THR_W'(10);

  typedef struct packed {
    logic                  action;
    logic [FAULT_ID_W-1:0] fault_id;
    logic                  cond_seen;
  } fmf_req_t;

  typedef struct packed {
    logic               state_changed;
    logic               fault_active;
    logic               id_valid;
    logic               any_active;
    logic [COUNT_W-1:0] active_count;
    logic [MASK_W-1:0]  active_mask;
  } fmf_res_t;

  typedef struct packed {
    logic [THR_W-1:0] mat_thr;
    logic [THR_W-1:0] heal_thr;
  } fmf_cfg_t;

endpackage

// File: design/fault_maturation_filter_core.sv
// a taken request's result is registered in the output register, or in the skid entry while the output waits
// throughput: one request per cycle while in_stall_o is low; the bank update is combinational logic
// a two-entry output buffer keeps taking requests while one result waits
// reset (async, active low) clears all flags and counters and loads thresholds 5 and 10
module fault_maturation_filter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  fmf_pkg::fmf_req_t                 in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output fmf_pkg::fmf_res_t                 out_res_o,
  input  logic                              cfg_we_i,
  input  logic [fmf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fmf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import fmf_pkg::*;

  fmf_cfg_t cfg_q;
  fmf_res_t res;
  logic     full;
  logic     push;

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mat_thr  <= MAT_THR_RST;
      cfg_q.heal_thr <= HEAL_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAT_THR:  cfg_q.mat_thr  <= THR_W'(cfg_data_i);
        CFG_HEAL_THR: cfg_q.heal_thr <= THR_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  fmf_bank u_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .req_i  (in_req_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  fmf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

// File: design/fmf_bank.sv
module fmf_bank (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fmf_pkg::fmf_req_t req_i,
  input  fmf_pkg::fmf_cfg_t cfg_i,
  output fmf_pkg::fmf_res_t res_o
);
  import fmf_pkg::*;

  function automatic logic [CNT_W-1:0] cnt_bump(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  logic                  id_valid;
  logic                  eval;
  logic [NUM_FAULTS-1:0] sel;
  logic [NUM_FAULTS-1:0] flags_q, flags_d;
  logic [CNT_W-1:0]      mat_q  [NUM_FAULTS];
  logic [CNT_W-1:0]      mat_d  [NUM_FAULTS];
  logic [CNT_W-1:0]      heal_q [NUM_FAULTS];
  logic [CNT_W-1:0]      heal_d [NUM_FAULTS];
  logic [SUM_W-1:0]      sum;
  logic [MASK_W-1:0]     mask;

  assign id_valid = {1'b0, req_i.fault_id} < (FAULT_ID_W + 1)'(NUM_FAULTS);
  assign eval     = !req_i.action && id_valid;

  for (genvar i = 0; i < NUM_FAULTS; i++) begin : g_entry
    logic [CNT_W-1:0] bumped_m;
    logic [CNT_W-1:0] bumped_h;

    assign sel[i]   = eval && (req_i.fault_id == FAULT_ID_W'(i));
    assign bumped_m = cnt_bump(mat_q[i]);
    assign bumped_h = cnt_bump(heal_q[i]);

    always_comb begin
      flags_d[i] = flags_q[i];
      mat_d[i]   = mat_q[i];
      heal_d[i]  = heal_q[i];
      if (req_i.action) begin
        flags_d[i] = 1'b0;
        mat_d[i]   = '0;
        heal_d[i]  = '0;
      end else if (sel[i]) begin
        if (req_i.cond_seen) begin
          heal_d[i] = '0;
          if (!flags_q[i]) begin
            if (bumped_m >= cfg_i.mat_thr) begin
              flags_d[i] = 1'b1;
              mat_d[i]   = '0;
            end else begin
              mat_d[i] = bumped_m;
            end
          end
        end else begin
          mat_d[i] = '0;
          if (flags_q[i]) begin
            if (bumped_h >= cfg_i.heal_thr) begin
              flags_d[i] = 1'b0;
              heal_d[i]  = '0;
            end else begin
              heal_d[i] = bumped_h;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        flags_q[i] <= 1'b0;
        mat_q[i]   <= '0;
        heal_q[i]  <= '0;
      end else if (push_i) begin
        flags_q[i] <= flags_d[i];
        mat_q[i]   <= mat_d[i];
        heal_q[i]  <= heal_d[i];
      end
    end
  end

  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < NUM_FAULTS) begin : g_used
      assign mask[i] = flags_d[i];
    end else begin : g_unused
      assign mask[i] = 1'b0;
    end
  end

  always_comb begin
    sum                 = '0;
    res_o.state_changed = 1'b0;
    res_o.fault_active  = 1'b0;
    for (int i = 0; i < NUM_FAULTS; i++) begin
      sum                 = sum + SUM_W'(flags_d[i]);
      res_o.state_changed = res_o.state_changed | (sel[i] & (flags_d[i] ^ flags_q[i]));
      res_o.fault_active  = res_o.fault_active | (sel[i] & flags_d[i]);
    end
    res_o.id_valid     = id_valid;
    res_o.any_active   = (sum != '0);
    res_o.active_count = COUNT_W'(sum);
    res_o.active_mask  = mask;
  end

`ifndef ASSERT_OFF
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && req_i.action) |=> (flags_q == '0))
    else $error("bank not empty after clear request");

  a_change_needs_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.state_changed |-> (res_o.id_valid && !req_i.action))
    else $error("state change reported without a valid evaluation");

  a_idle_heal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flags_q[0] |-> (heal_q[0] == '0))
    else $error("inactive fault holds a healing count");

  a_active_mat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q[0] |-> (mat_q[0] == '0))
    else $error("active fault holds a maturation count");
`endif

endmodule

// File: design/fmf_out_buf.sv
module fmf_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fmf_pkg::fmf_res_t res_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fmf_pkg::fmf_res_t out_res_o
);
  import fmf_pkg::*;

  logic     out_valid_q;
  logic     skid_valid_q;
  fmf_res_t out_q;
  fmf_res_t skid_q;
  logic     pop;

  assign pop = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload follows the same priority as the valid bits
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || pop) begin
      if (push_i) begin
        out_q <= res_i;
      end
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && pop) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry lost on drain");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("request pushed into full buffer");
`endif

endmodule

// File: dv/fault_maturation_filter_core_test.sv
module fault_maturation_filter_core_test;
  import fmf_pkg::*;

  localparam logic ACT_EVAL  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned NUM_PHASES = 10;

  typedef struct packed {
    fmf_req_t req;
    logic     pinned;
    fmf_res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fmf_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fmf_res_t out_res;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_MAT_THR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // golden value travels with the request it belongs to
  logic req_pinned = 1'b0;
  fmf_res_t req_golden = '0;

  logic calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // filter bank as the block should see it
  logic [NUM_FAULTS-1:0] latched;
  logic [CNT_W-1:0] mature_cnt [NUM_FAULTS];
  logic [CNT_W-1:0] heal_cnt [NUM_FAULTS];
  logic [THR_W-1:0] mat_thr = MAT_THR_RST;
  logic [THR_W-1:0] heal_thr = HEAL_THR_RST;
  fmf_res_t pending_results [$];

  fault_maturation_filter_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void wipe_bank();
    latched = '0;
    foreach (mature_cnt[i]) begin
      mature_cnt[i] = '0;
      heal_cnt[i] = '0;
    end
  endfunction

  function automatic fmf_res_t filter_step(fmf_req_t r);
    fmf_res_t res;
    logic was;
    int unsigned id;
    int unsigned ones;
    logic [31:0] mask;
    res = '0;
    ones = 0;
    mask = '0;
    id = r.fault_id;
    res.id_valid = (id < NUM_FAULTS);
    if (r.action == ACT_CLEAR) begin
      wipe_bank();
    end else if (res.id_valid) begin
      was = latched[id];
      if (r.cond_seen) begin
        heal_cnt[id] = '0;
        if (!latched[id]) begin
          if (mature_cnt[id] != '1) mature_cnt[id] = mature_cnt[id] + 1'b1;
          if (mature_cnt[id] >= mat_thr) begin
            latched[id] = 1'b1;
            mature_cnt[id] = '0;
          end
        end
      end else begin
        mature_cnt[id] = '0;
        if (latched[id]) begin
          if (heal_cnt[id] != '1) heal_cnt[id] = heal_cnt[id] + 1'b1;
          if (heal_cnt[id] >= heal_thr) begin
            latched[id] = 1'b0;
            heal_cnt[id] = '0;
          end
        end
      end
      res.state_changed = (latched[id] != was);
      res.fault_active = latched[id];
    end
    for (int i = 0; i < NUM_FAULTS; i++) begin
      if (latched[i]) begin
        ones++;
        mask[i] = 1'b1;
      end
    end
    res.any_active = (ones != 0);
    res.active_count = COUNT_W'(ones);
    res.active_mask = mask[MASK_W-1:0];
    return res;
  endfunction

  function automatic fmf_req_t make_req(logic act, int unsigned id, logic pres);
    fmf_req_t r;
    r.action = act;
    r.fault_id = FAULT_ID_W'(id);
    r.cond_seen = pres;
    return r;
  endfunction

  function automatic row_t row(logic act, int unsigned id, logic pres, logic pin,
                               fmf_res_t res);
    row_t x;
    x.req = make_req(act, id, pres);
    x.pinned = pin;
    x.res = res;
    return x;
  endfunction

  task automatic report(string field, int unsigned want, int unsigned got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endtask

  // request and result bookkeeping, sampled on pre-edge values
  always @(posedge clk) begin
    fmf_res_t want;
    fmf_res_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual %h", $time, out_res);
        end else begin
          want = pending_results.pop_front();
          if (out_res.state_changed !== want.state_changed)
            report("state_changed", want.state_changed, out_res.state_changed);
          if (out_res.fault_active !== want.fault_active)
            report("fault_active", want.fault_active, out_res.fault_active);
          if (out_res.id_valid !== want.id_valid)
            report("id_valid", want.id_valid, out_res.id_valid);
          if (out_res.any_active !== want.any_active)
            report("any_active", want.any_active, out_res.any_active);
          if (out_res.active_count !== want.active_count)
            report("active_count", want.active_count, out_res.active_count);
          if (out_res.active_mask !== want.active_mask)
            report("active_mask", want.active_mask, out_res.active_mask);
        end
      end
      if (in_valid && !in_stall) begin
        got = filter_step(in_req);
        pending_results.push_back(req_pinned ? req_golden : got);
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_MAT_THR) mat_thr = cfg_data;
        else if (cfg_idx == CFG_HEAL_THR) heal_thr = cfg_data;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 24);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(fmf_req_t r, logic pin, fmf_res_t golden);
    in_valid <= 1'b1;
    in_req <= r;
    req_pinned <= pin;
    req_golden <= golden;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_thresholds(logic [THR_W-1:0] mat, logic [THR_W-1:0] heal);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MAT_THR;
    cfg_data <= mat;
    @(posedge clk);
    cfg_idx <= CFG_HEAL_THR;
    cfg_data <= heal;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // runs of same-sense evaluations on one fault, with stray and clearing requests
  task automatic random_phase(int unsigned n);
    int unsigned done_items;
    int unsigned burst;
    int unsigned id;
    int unsigned thr;
    int unsigned roll;
    logic pres;
    done_items = 0;
    while (done_items < n) begin
      id = $urandom_range(0, NUM_FAULTS - 1);
      pres = 1'($urandom_range(0, 1));
      thr = pres ? mat_thr : heal_thr;
      if (thr > 30) thr = 30;
      burst = $urandom_range(1, thr + 2);
      for (int k = 0; k < burst; k++) begin
        roll = $urandom_range(99);
        if (roll < 2)
          send(make_req(ACT_CLEAR, $urandom_range(0, 15), 1'($urandom_range(0, 1))),
               1'b0, '0);
        else if (roll < 10)
          send(make_req(ACT_EVAL, $urandom_range(NUM_FAULTS, 15),
                        1'($urandom_range(0, 1))), 1'b0, '0);
        else if (roll < 14)
          send(make_req(ACT_EVAL, $urandom_range(0, NUM_FAULTS - 1),
                        1'($urandom_range(0, 1))), 1'b0, '0);
        else
          send(make_req(ACT_EVAL, id, pres), 1'b0, '0);
        done_items++;
      end
    end
  endtask

  initial begin
    row_t directed [$];
    logic [THR_W-1:0] mat_plan [NUM_PHASES];
    logic [THR_W-1:0] heal_plan [NUM_PHASES];
    mat_plan  = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd3, 8'd255, 8'd1, 8'd5, 8'd0, 8'd0};
    heal_plan = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd2, 8'd1, 8'd255, 8'd10, 8'd0, 8'd0};
    wipe_bank();

    // reset thresholds 5 and 10 hold for the whole table
    directed.push_back(row(ACT_EVAL, 0, 1'b0, 1'b1, {4'b0010, 4'd0, 8'h00}));
    directed.push_back(row(ACT_EVAL, 15, 1'b1, 1'b1, {4'b0000, 4'd0, 8'h00}));
    directed.push_back(row(ACT_EVAL, 8, 1'b1, 1'b1, {4'b0000, 4'd0, 8'h00}));
    directed.push_back(row(ACT_CLEAR, 9, 1'b1, 1'b1, {4'b0000, 4'd0, 8'h00}));
    directed.push_back(row(ACT_CLEAR, 2, 1'b0, 1'b1, {4'b0010, 4'd0, 8'h00}));
    repeat (4) directed.push_back(row(ACT_EVAL, 7, 1'b1, 1'b0, '0));
    directed.push_back(row(ACT_EVAL, 7, 1'b1, 1'b1, {4'b1111, 4'd1, 8'h80}));
    directed.push_back(row(ACT_EVAL, 7, 1'b1, 1'b1, {4'b0111, 4'd1, 8'h80}));
    // an absent evaluation restarts the maturation count
    directed.push_back(row(ACT_EVAL, 0, 1'b1, 1'b0, '0));
    directed.push_back(row(ACT_EVAL, 0, 1'b0, 1'b0, '0));
    repeat (4) directed.push_back(row(ACT_EVAL, 0, 1'b1, 1'b0, '0));
    directed.push_back(row(ACT_EVAL, 0, 1'b1, 1'b1, {4'b1111, 4'd2, 8'h81}));
    directed.push_back(row(ACT_EVAL, 7, 1'b0, 1'b0, '0));
    directed.push_back(row(ACT_EVAL, 7, 1'b1, 1'b0, '0));
    directed.push_back(row(ACT_EVAL, 12, 1'b0, 1'b1, {4'b0001, 4'd2, 8'h81}));
    directed.push_back(row(ACT_CLEAR, 0, 1'b0, 1'b1, {4'b0010, 4'd0, 8'h00}));
    directed.push_back(row(ACT_EVAL, 5, 1'b0, 1'b0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send(directed[i].req, directed[i].pinned, directed[i].res);

    mat_plan[8] = THR_W'($urandom_range(1, 40));
    heal_plan[8] = THR_W'($urandom_range(1, 40));
    mat_plan[9] = THR_W'($urandom_range(0, 255));
    heal_plan[9] = THR_W'($urandom_range(0, 255));

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_thresholds(mat_plan[p], heal_plan[p]);
      calm = (p == 4);
      if (mat_plan[p] == 8'd255 && heal_plan[p] == 8'd255) begin
        // counters run all the way to the ceiling before latching and healing
        send(make_req(ACT_CLEAR, 0, 1'b0), 1'b0, '0);
        repeat (255) send(make_req(ACT_EVAL, 6, 1'b1), 1'b0, '0);
        repeat (255) send(make_req(ACT_EVAL, 6, 1'b0), 1'b0, '0);
        // threshold lowered under a running count
        repeat (40) send(make_req(ACT_EVAL, 2, 1'b1), 1'b0, '0);
        set_thresholds(8'd3, 8'd255);
        send(make_req(ACT_EVAL, 2, 1'b1), 1'b0, '0);
      end
      random_phase(110);
    end
    calm = 1'b0;

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
